>>> hdl/band_gap_extrema_analyzer_core_defines.svh
// Assertion macros shared by the checker of the band gap extrema analyzer.
// No dependencies.
`ifndef BAND_GAP_EXTREMA_ANALYZER_CORE_DEFINES_SVH
`define BAND_GAP_EXTREMA_ANALYZER_CORE_DEFINES_SVH
// antecedent implies consequent in the next cycle
`define BGEA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// antecedent implies consequent in the same cycle
`define BGEA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

>>> hdl/bgea_pkg.sv
// Package of the band gap extrema analyzer: widths, sizes, states, register codes.
// No dependencies.
package bgea_pkg;
   localparam int MAX_SPINS    = 2;
   localparam int MAX_KPOINTS  = 64;
   localparam int MAX_BANDS    = 64;
   localparam int ENERGY_WIDTH = 32;
   localparam int KP_W         = 6;
   localparam int BAND_W       = 6;
   localparam int CFG_W        = 32;
   localparam int CFG_IDX_W    = 2;

   localparam logic [CFG_IDX_W-1:0] REG_FERMI = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_TOL   = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_KPTS  = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_LOAD  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;
endpackage

>>> hdl/bgea_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bgea_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hdl/band_gap_extrema_analyzer_core.sv
// Top level of the band gap extrema analyzer: band and k-point stores, scan, result.
// Depends on bgea_pkg and bgea_ram.
//
//   channel | dir | handshake     | payload
//   req_    | in  | tvalid/tready | tdata{energy,band,kpoint,spin}, tuser{finite}, tlast
//   rsp_    | out | tvalid/tready | tdata result record
//   csr_    | in  | wr_en         | idx, data
//
// A sample is read from the band and k-point entries, then folded and written back;
// no new word is taken meanwhile. The last sample starts a scan over the stores,
// band entries then k-point entries, through their read ports, then the result
// waits in an output register. After reset and after every result a clearing pass
// writes every entry back to zero; no word is taken meanwhile.
// A stalled result holds the block; nothing is taken until it leaves.
module band_gap_extrema_analyzer_core #(
   parameter int MAX_BANDS   = bgea_pkg::MAX_BANDS,
   parameter int MAX_KPOINTS = bgea_pkg::MAX_KPOINTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // bits: spin[0] kpoint[6:1] band[12:7] energy[44:13], zero pad to 48
   input  logic [47:0] req_tdata,
   // bits: finite[0]
   input  logic        req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // bits: valid_res[0] metallic[1] direct[2] gap[34:3] vbm[66:35] cbm[98:67]
   // vbm_kpoint[104:99] vbm_spin[105] cbm_kpoint[111:106] cbm_spin[112]
   // direct_gap[144:113] direct_kpoint[150:145], zero pad to 152
   output logic [151:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [bgea_pkg::CFG_IDX_W-1:0] csr_idx,
   input  logic [bgea_pkg::CFG_W-1:0]     csr_data
);
   localparam int NB   = 2 * MAX_BANDS;
   localparam int BA_W = $clog2(NB);
   localparam int KA_W = $clog2(MAX_KPOINTS);
   localparam int CLR_N = (NB > MAX_KPOINTS) ? NB : MAX_KPOINTS;
   localparam int CNT_W = $clog2(NB + MAX_KPOINTS + 4);
   localparam int BREC_W = 2*32 + 2*6 + 1;  // lo, hi, lo_at, hi_at, seen
   localparam int KREC_W = 2*32 + 2;        // top occ, bottom empty, occ seen, empty seen

   bgea_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic signed [31:0] fermi_ff;
   logic [30:0] tol_ff;
   logic [6:0]  kpts_ff;

   // sample pipeline
   logic        s1_v_ff;
   logic        s1_last_ff, s1_ok_ff;
   logic [BA_W-1:0] s1_b_ff;
   logic [KA_W-1:0] s1_k_ff;
   logic [5:0]  s1_kp_ff;
   logic signed [31:0] s1_e_ff;
   logic        s1_occ_ff;

   logic        b_we, k_we;
   logic [BA_W-1:0] b_wa, b_ra;
   logic [KA_W-1:0] k_wa, k_ra;
   logic [BREC_W-1:0] b_wd, b_rd;
   logic [KREC_W-1:0] k_wd, k_rd;

   bgea_ram #(.WIDTH(BREC_W), .DEPTH(NB)) u_band_ram (
      .clock(clock), .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd),
      .rd_addr(b_ra), .rd_data(b_rd));
   bgea_ram #(.WIDTH(KREC_W), .DEPTH(MAX_KPOINTS)) u_kpt_ram (
      .clock(clock), .wr_en(k_we), .wr_addr(k_wa), .wr_data(k_wd),
      .rd_addr(k_ra), .rd_data(k_rd));

   wire        in_spin   = req_tdata[0];
   wire [5:0]  in_kp     = req_tdata[6:1];
   wire [5:0]  in_band   = req_tdata[12:7];
   wire signed [31:0] in_e = req_tdata[44:13];
   wire in_ok = req_tuser && (32'(in_kp) < MAX_KPOINTS) && (32'(in_band) < MAX_BANDS);

   assign req_tready = (state_ff == bgea_pkg::ST_LOAD) && !s1_v_ff;
   wire acc = req_tvalid && req_tready;

   // unpack read records
   wire signed [31:0] r_lo = b_rd[31:0];
   wire signed [31:0] r_hi = b_rd[63:32];
   wire [5:0] r_lo_at = b_rd[69:64];
   wire [5:0] r_hi_at = b_rd[75:70];
   wire       r_seen  = b_rd[76];
   wire signed [31:0] r_top = k_rd[31:0];
   wire signed [31:0] r_bot = k_rd[63:32];
   wire       r_os = k_rd[64];
   wire       r_es = k_rd[65];

   // scan state
   logic signed [31:0] vbm_ff, cbm_ff;
   logic [5:0] vk_ff, ck_ff, dk_ff;
   logic vs_ff, cs_ff, sawv_ff, sawc_ff, done_ff, have_ff;
   logic signed [32:0] best_ff;
   logic [151:0] res_ff;
   logic rsp_v_ff;

   // scan read index and the index whose data arrives this cycle
   wire [CNT_W-1:0] rd_i = cnt_ff - CNT_W'(1);
   wire in_band_ph = (cnt_ff >= CNT_W'(1)) && (cnt_ff <= CNT_W'(NB));
   wire in_kpt_ph  = (cnt_ff >= CNT_W'(NB+1)) && (cnt_ff <= CNT_W'(NB+MAX_KPOINTS));
   wire [CNT_W-1:0] k_i = rd_i - CNT_W'(NB);
   wire cur_spin = (rd_i >= CNT_W'(MAX_BANDS));
   logic [6:0] kc;
   assign kc = (kpts_ff > 7'(MAX_KPOINTS)) ? 7'(MAX_KPOINTS) : kpts_ff;

   // final classification
   wire signed [32:0] g = 33'(cbm_ff) - 33'(vbm_ff);
   wire bracket = !done_ff && sawv_ff && sawc_ff;
   wire metal = done_ff || (bracket && (g <= 33'(tol_ff)));
   wire normal = bracket && !metal;
   wire [31:0] gsat = g[32] ? 32'd0 : g[31:0];
   wire [31:0] bsat = best_ff[32] ? 32'd0 : best_ff[31:0];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      b_we = 1'b0; k_we = 1'b0;
      b_wa = s1_b_ff; k_wa = s1_k_ff;
      b_wd = '0; k_wd = '0;
      b_ra = BA_W'(in_spin * MAX_BANDS + 32'(in_band));
      k_ra = KA_W'(in_kp);
      unique case (state_ff)
         bgea_pkg::ST_CLEAR: begin
            b_we = (32'(cnt_ff) < NB);
            k_we = (32'(cnt_ff) < MAX_KPOINTS);
            b_wa = BA_W'(cnt_ff);
            k_wa = KA_W'(cnt_ff);
            cnt_in = cnt_ff + CNT_W'(1);
            if (32'(cnt_ff) == CLR_N - 1) begin
               state_in = bgea_pkg::ST_LOAD;
               cnt_in = '0;
            end
         end
         bgea_pkg::ST_LOAD: begin
            if (s1_v_ff) begin
               // fold the sample into the entries just read
               b_we = s1_ok_ff;
               k_we = s1_ok_ff;
               if (!r_seen) begin
                  b_wd = {1'b1, s1_kp_ff, s1_kp_ff, s1_e_ff, s1_e_ff};
               end else begin
                  b_wd = b_rd;
                  if (s1_e_ff < r_lo || (s1_e_ff == r_lo && s1_kp_ff < r_lo_at)) begin
                     b_wd[31:0] = s1_e_ff; b_wd[69:64] = s1_kp_ff;
                  end
                  if (s1_e_ff > r_hi || (s1_e_ff == r_hi && s1_kp_ff < r_hi_at)) begin
                     b_wd[63:32] = s1_e_ff; b_wd[75:70] = s1_kp_ff;
                  end
               end
               k_wd = k_rd;
               if (s1_occ_ff) begin
                  if (!r_os || s1_e_ff > r_top) k_wd[31:0] = s1_e_ff;
                  k_wd[64] = 1'b1;
               end else begin
                  if (!r_es || s1_e_ff < r_bot) k_wd[63:32] = s1_e_ff;
                  k_wd[65] = 1'b1;
               end
               if (s1_last_ff) begin
                  state_in = bgea_pkg::ST_SCAN;
                  cnt_in = '0;
               end
            end
         end
         bgea_pkg::ST_SCAN: begin
            b_ra = BA_W'(cnt_ff);
            k_ra = KA_W'(cnt_ff - CNT_W'(NB));
            cnt_in = cnt_ff + CNT_W'(1);
            // leave in the cycle after the last k-point entry has been folded
            if (cnt_ff == CNT_W'(NB + MAX_KPOINTS + 1)) begin
               state_in = bgea_pkg::ST_OUT;
            end
         end
         bgea_pkg::ST_OUT: begin
            if (rsp_v_ff && rsp_tready) begin
               state_in = bgea_pkg::ST_CLEAR;
               cnt_in = '0;
            end
         end
         default: state_in = bgea_pkg::ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bgea_pkg::ST_CLEAR;
         cnt_ff   <= '0;
         s1_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
         fermi_ff <= '0;
         tol_ff   <= 31'd66;
         kpts_ff  <= 7'd64;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         s1_v_ff  <= acc;
         if (csr_wr_en) begin
            unique case (csr_idx)
               bgea_pkg::REG_FERMI: fermi_ff <= csr_data;
               bgea_pkg::REG_TOL:   tol_ff   <= csr_data[30:0];
               bgea_pkg::REG_KPTS:  kpts_ff  <= csr_data[6:0];
               default: ;
            endcase
         end
         if (state_ff == bgea_pkg::ST_SCAN && state_in == bgea_pkg::ST_OUT) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_last_ff <= req_tlast;
         s1_ok_ff   <= in_ok;
         s1_b_ff    <= b_ra;
         s1_k_ff    <= k_ra;
         s1_kp_ff   <= in_kp;
         s1_e_ff    <= in_e;
         s1_occ_ff  <= (in_e <= fermi_ff);
      end
      if (state_ff == bgea_pkg::ST_LOAD && state_in == bgea_pkg::ST_SCAN) begin
         // reset scan accumulators
         {sawv_ff, sawc_ff, done_ff, have_ff} <= '0;
         {vbm_ff, cbm_ff, vk_ff, ck_ff, dk_ff, vs_ff, cs_ff} <= '0;
         best_ff <= '0;
      end
      if (state_ff == bgea_pkg::ST_SCAN && in_band_ph && r_seen && !done_ff) begin
         if (r_lo <= fermi_ff && r_hi > fermi_ff) begin
            done_ff <= 1'b1;
         end else if (r_hi <= fermi_ff) begin
            if (!sawv_ff || r_hi > vbm_ff) begin
               vbm_ff <= r_hi; vk_ff <= r_hi_at; vs_ff <= cur_spin;
            end
            sawv_ff <= 1'b1;
         end else begin
            if (!sawc_ff || r_lo < cbm_ff) begin
               cbm_ff <= r_lo; ck_ff <= r_lo_at; cs_ff <= cur_spin;
            end
            sawc_ff <= 1'b1;
         end
      end
      if (state_ff == bgea_pkg::ST_SCAN && in_kpt_ph && r_os && r_es
          && (k_i < CNT_W'(kc))) begin
         if (!have_ff || (33'(r_bot) - 33'(r_top)) < best_ff) begin
            best_ff <= 33'(r_bot) - 33'(r_top);
            dk_ff <= 6'(k_i);
            have_ff <= 1'b1;
         end
      end
      if (state_ff == bgea_pkg::ST_SCAN && state_in == bgea_pkg::ST_OUT) begin
         // pack the record from the top bit down
         res_ff <= {1'b0,
                    (normal && have_ff) ? dk_ff : 6'd0,
                    normal ? (have_ff ? bsat : gsat) : 32'd0,
                    cs_ff, ck_ff, vs_ff, vk_ff,
                    bracket ? cbm_ff : 32'sd0,
                    bracket ? vbm_ff : 32'sd0,
                    normal ? gsat : 32'd0,
                    normal && (vk_ff == ck_ff),
                    metal,
                    done_ff || bracket};
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = res_ff;
endmodule

>>> hdl/bgea_checker.sv
// Port checker for the band gap extrema analyzer, bound to the top level.
// Depends on band_gap_extrema_analyzer_core_defines.svh.
`include "band_gap_extrema_analyzer_core_defines.svh"
module bgea_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic req_tlast,
   input logic rsp_tvalid,
   input logic rsp_tready
);
   `BGEA_ASSERT_NOW(a_no_take_during_result, clock, reset, rsp_tvalid, !req_tready, "word taken while result pending")
   `BGEA_ASSERT_NEXT(a_no_back_to_back, clock, reset, req_tvalid && req_tready, !req_tready, "words taken back to back")
   `BGEA_ASSERT_NEXT(a_last_no_take, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready && !rsp_tvalid, "word taken after last")
   `BGEA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped")
endmodule

bind band_gap_extrema_analyzer_core bgea_checker u_bgea_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tlast(req_tlast), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready));

>>> verif/tb.sv
// Self-checking bench for band_gap_extrema_analyzer_core: streams energy samples in
// data sets, predicts each result record in-bench and compares it field by field.
// Depends on bgea_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

   localparam int SLOTS      = 2 * bgea_pkg::MAX_BANDS;
   localparam int SETTLE     = 400;   // scan + clearing pass, with margin
   localparam int IDLE_LIMIT = 5000;  // cycles with no word moving

   typedef struct {
      bit               valid_res;
      bit               metallic;
      bit               direct;
      bit [31:0]        gap;
      logic signed [31:0] vbm;
      logic signed [31:0] cbm;
      bit [5:0]         vbm_kpoint;
      bit               vbm_spin;
      bit [5:0]         cbm_kpoint;
      bit               cbm_spin;
      bit [31:0]        direct_gap;
      bit [5:0]         direct_kpoint;
   } gap_record_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [47:0]  req_tdata;   // spin[0] kpoint[6:1] band[12:7] energy[44:13]
   logic         req_tuser;   // finite[0]
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [151:0] rsp_tdata;   // valid_res metallic direct gap vbm cbm vbm_kpoint vbm_spin
                              // cbm_kpoint cbm_spin direct_gap direct_kpoint
   logic         csr_wr_en;
   logic [bgea_pkg::CFG_IDX_W-1:0] csr_idx;
   logic [bgea_pkg::CFG_W-1:0]     csr_data;

   band_gap_extrema_analyzer_core u_dut (.*);

   // clock: 2 ns period
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // shadow configuration
   logic signed [31:0] fermi_shadow;
   bit [30:0]          tol_shadow;
   bit [6:0]           kpts_shadow;

   // shadow per-set stores
   logic signed [31:0] band_lo[SLOTS];
   logic signed [31:0] band_hi[SLOTS];
   bit [5:0]           band_lo_k[SLOTS];
   bit [5:0]           band_hi_k[SLOTS];
   bit                 band_seen[SLOTS];
   logic signed [31:0] k_top_occ[bgea_pkg::MAX_KPOINTS];
   logic signed [31:0] k_bot_emp[bgea_pkg::MAX_KPOINTS];
   bit                 k_occ_seen[bgea_pkg::MAX_KPOINTS];
   bit                 k_emp_seen[bgea_pkg::MAX_KPOINTS];

   gap_record_type pending_records[$];
   int          fail_count;
   int          words_sent;
   int          records_seen;
   bit          calm;        // when set, neither side idles
   int          idle_cycles;

   function automatic bit [31:0] clip_gap(longint g);
      if (g < 0) return 32'd0;
      if (g > longint'(32'hFFFF_FFFF)) return 32'hFFFF_FFFF;
      return g[31:0];
   endfunction

   function automatic void clear_stores();
      for (int i = 0; i < SLOTS; i++) begin
         band_lo[i] = 0; band_hi[i] = 0; band_lo_k[i] = 0; band_hi_k[i] = 0;
         band_seen[i] = 0;
      end
      for (int k = 0; k < bgea_pkg::MAX_KPOINTS; k++) begin
         k_top_occ[k] = 0; k_bot_emp[k] = 0; k_occ_seen[k] = 0; k_emp_seen[k] = 0;
      end
   endfunction

   // fold one accepted sample into the shadow stores
   function automatic void fold_sample(bit sp, bit [5:0] kp, bit [5:0] bd,
                                       logic signed [31:0] e, bit fin);
      int i;
      i = sp * bgea_pkg::MAX_BANDS + bd;
      if (!fin) return;
      if (!band_seen[i]) begin
         band_seen[i] = 1;
         band_lo[i] = e; band_hi[i] = e; band_lo_k[i] = kp; band_hi_k[i] = kp;
      end else begin
         if (e < band_lo[i] || (e == band_lo[i] && kp < band_lo_k[i])) begin
            band_lo[i] = e; band_lo_k[i] = kp;
         end
         if (e > band_hi[i] || (e == band_hi[i] && kp < band_hi_k[i])) begin
            band_hi[i] = e; band_hi_k[i] = kp;
         end
      end
      if (e <= fermi_shadow) begin
         if (!k_occ_seen[kp] || e > k_top_occ[kp]) k_top_occ[kp] = e;
         k_occ_seen[kp] = 1;
      end else begin
         if (!k_emp_seen[kp] || e < k_bot_emp[kp]) k_bot_emp[kp] = e;
         k_emp_seen[kp] = 1;
      end
   endfunction

   // classify bands in spin-then-band order and build the record
   function automatic gap_record_type classify_bands();
      gap_record_type r;
      bit          saw_v, saw_c, crossed, have;
      longint      vbm_e, cbm_e, g, best, v;
      int          kc;
      r = '{default: 0};
      saw_v = 0; saw_c = 0; crossed = 0; vbm_e = 0; cbm_e = 0;
      for (int i = 0; i < SLOTS && !crossed; i++) begin
         if (band_seen[i]) begin
            if (band_lo[i] <= fermi_shadow && band_hi[i] > fermi_shadow) begin
               // a crossing band ends the scan: metallic, gap zero
               r.valid_res = 1; r.metallic = 1; crossed = 1;
            end else if (band_hi[i] <= fermi_shadow) begin
               if (!saw_v || band_hi[i] > vbm_e) begin
                  vbm_e = band_hi[i]; r.vbm_kpoint = band_hi_k[i];
                  r.vbm_spin = (i >= bgea_pkg::MAX_BANDS);
               end
               saw_v = 1;
            end else begin
               if (!saw_c || band_lo[i] < cbm_e) begin
                  cbm_e = band_lo[i]; r.cbm_kpoint = band_lo_k[i];
                  r.cbm_spin = (i >= bgea_pkg::MAX_BANDS);
               end
               saw_c = 1;
            end
         end
      end
      if (!crossed && saw_v && saw_c) begin
         g = cbm_e - vbm_e;
         r.valid_res = 1; r.vbm = 32'(vbm_e); r.cbm = 32'(cbm_e);
         if (g <= longint'(tol_shadow)) begin
            r.metallic = 1;
         end else begin
            r.gap    = clip_gap(g);
            r.direct = (r.vbm_kpoint == r.cbm_kpoint);
            kc   = (kpts_shadow > bgea_pkg::MAX_KPOINTS) ? bgea_pkg::MAX_KPOINTS
                                                         : kpts_shadow;
            have = 0; best = 0;
            for (int k = 0; k < kc; k++) begin
               if (k_occ_seen[k] && k_emp_seen[k]) begin
                  v = longint'(k_bot_emp[k]) - longint'(k_top_occ[k]);
                  if (!have || v < best) begin
                     best = v; r.direct_kpoint = 6'(k); have = 1;
                  end
               end
            end
            r.direct_gap = have ? clip_gap(best) : r.gap;
         end
      end
      return r;
   endfunction

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v !== act_v) begin
         $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // result side: random stalls, compare each word with the oldest expectation
   int stall_left;
   always @(posedge clock) begin
      int n;
      gap_record_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         records_seen++;
         if (pending_records.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual %h",
                     $time, rsp_tdata);
            fail_count++;
         end else begin
            e = pending_records.pop_front();
            check_field("valid_res",     e.valid_res,     rsp_tdata[0]);
            check_field("metallic",      e.metallic,      rsp_tdata[1]);
            check_field("direct",        e.direct,        rsp_tdata[2]);
            check_field("gap",           e.gap,           rsp_tdata[34:3]);
            check_field("vbm",           $unsigned(e.vbm), rsp_tdata[66:35]);
            check_field("cbm",           $unsigned(e.cbm), rsp_tdata[98:67]);
            check_field("vbm_kpoint",    e.vbm_kpoint,    rsp_tdata[104:99]);
            check_field("vbm_spin",      e.vbm_spin,      rsp_tdata[105]);
            check_field("cbm_kpoint",    e.cbm_kpoint,    rsp_tdata[111:106]);
            check_field("cbm_spin",      e.cbm_spin,      rsp_tdata[112]);
            check_field("direct_gap",    e.direct_gap,    rsp_tdata[144:113]);
            check_field("direct_kpoint", e.direct_kpoint, rsp_tdata[150:145]);
         end
         n = calm ? 0 : $urandom_range(0, 5);
         stall_left <= n;
         rsp_tready <= (n == 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: end the run if no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // send one sample; valid stays high across back-to-back words
   task automatic send_sample(bit sp, bit [5:0] kp, bit [5:0] bd,
                              logic signed [31:0] e, bit fin, bit lst);
      int gap_cycles;
      gap_cycles = calm ? 0 : $urandom_range(0, 5);
      if (gap_cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap_cycles) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b0, e, bd, kp, sp};
      req_tuser  <= fin;
      req_tlast  <= lst;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      fold_sample(sp, kp, bd, e, fin);
      if (lst) begin
         pending_records.push_back(classify_bands());
         clear_stores();
      end
   endtask

   // drop valid, wait until every expected record has come back, then optionally wait SETTLE
   task automatic drain(bit with_settle);
      req_tvalid <= 1'b0;
      wait (pending_records.size() == 0);
      @(posedge clock);
      if (with_settle) repeat (SETTLE) @(posedge clock);
   endtask

   // drive one register write; the caller drops the write enable
   task automatic write_reg(logic [bgea_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_idx   <= idx;
      csr_data  <= value;
      @(posedge clock);
      case (idx)
         bgea_pkg::REG_FERMI: fermi_shadow = value;
         bgea_pkg::REG_TOL:   tol_shadow   = value[30:0];
         bgea_pkg::REG_KPTS:  kpts_shadow  = value[6:0];
         default: ;
      endcase
   endtask

   task automatic set_config(logic [31:0] fermi, logic [31:0] tol, logic [31:0] kpts);
      drain(1'b1);
      write_reg(bgea_pkg::REG_FERMI, fermi);
      write_reg(bgea_pkg::REG_TOL, tol);
      write_reg(bgea_pkg::REG_KPTS, kpts);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647)  return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // directed sets: each special case of the classifier
   task automatic test_directed();
      // plain insulator, indirect: vbm at k3, cbm at k5
      send_sample(0, 3, 0, -32'sd65536, 1, 0);
      send_sample(0, 5, 0, -32'sd131072, 1, 0);
      send_sample(0, 5, 1, 32'sd65536, 1, 0);
      send_sample(0, 3, 1, 32'sd98304, 1, 1);
      // direct gap on spin 1, ties resolved toward the lower k-point
      send_sample(1, 9, 63, -32'sd100, 1, 0);
      send_sample(1, 2, 63, -32'sd100, 1, 0);
      send_sample(1, 2, 62, 32'sd500, 1, 0);
      send_sample(1, 63, 62, 32'sd500, 1, 1);
      // crossing band after an occupied one
      send_sample(0, 1, 4, -32'sd10, 1, 0);
      send_sample(0, 7, 5, -32'sd5, 1, 0);
      send_sample(0, 8, 5, 32'sd5, 1, 1);
      // only occupied bands: no bracket
      send_sample(1, 0, 0, -32'sd7, 1, 0);
      send_sample(0, 4, 2, 32'sd0, 1, 1);
      // gap inside the tolerance
      send_sample(0, 6, 0, -32'sd20, 1, 0);
      send_sample(0, 6, 1, 32'sd20, 1, 1);
      // non-finite samples are skipped, their last mark still closes the set
      send_sample(0, 0, 0, -32'sd1000, 1, 0);
      send_sample(0, 0, 0, 32'sd1000, 0, 0);
      send_sample(0, 0, 1, 32'sd2000, 1, 0);
      send_sample(1, 63, 63, 32'sh7FFF_FFFF, 0, 1);
      // full-scale energies: widest possible gap
      send_sample(0, 63, 0, 32'sh8000_0000, 1, 0);
      send_sample(1, 0, 63, 32'sh7FFF_FFFF, 1, 1);
      // empty set: a lone non-finite last word
      send_sample(1, 42, 21, 32'sh5555_AAAA, 0, 1);
   endtask

   // one data set with random content; band kinds fixed per set
   task automatic random_set(int len, int cross_pct);
      bit [1:0] kind[SLOTS];
      bit       sp, fin;
      bit [5:0] kp, bd;
      int       i;
      longint   off;
      logic signed [31:0] e;
      for (int j = 0; j < SLOTS; j++)
         kind[j] = ($urandom_range(0, 99) < cross_pct) ? 2'd2 : 2'($urandom_range(0, 1));
      for (int n = 0; n < len; n++) begin
         sp  = $urandom_range(0, 1);
         bd  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 5));
         kp  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(0, 7));
         fin = ($urandom_range(0, 15) != 0);
         i   = sp * bgea_pkg::MAX_BANDS + bd;
         off = $urandom_range(0, 1 << ($urandom_range(0, 3) * 6));
         case ($urandom_range(0, 19))
            0:       e = $urandom;
            default: begin
               if (kind[i] == 2'd2) kind[i] = 2'($urandom_range(0, 1));
               e = (kind[i] == 2'd0) ? clamp32(longint'(fermi_shadow) - off)
                                     : clamp32(longint'(fermi_shadow) + 1 + off);
            end
         endcase
         send_sample(sp, kp, bd, e, fin, n == len - 1);
      end
   endtask

   // sweep register settings, extremes among them
   task automatic test_config_sweep();
      set_config(32'h8000_0000, 32'd0, 32'd0);
      random_set(12, 0);
      random_set(6, 0);
      set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd127);
      random_set(12, 0);
      set_config(32'h0001_0000, 32'd300, 32'd4);
      random_set(20, 0);
      set_config(32'hFFFF_0000, 32'h0000_4000, 32'd64);
      random_set(20, 5);
      set_config(32'h0000_0000, 32'd66, 32'd1);
      random_set(15, 0);
   endtask

   // bulk random sets with occasional full drains and calm stretches
   task automatic test_random_sets();
      while (words_sent < 880) begin
         calm = ($urandom_range(0, 7) == 0);
         random_set($urandom_range(1, 30), $urandom_range(0, 3) == 0 ? 10 : 0);
         if ($urandom_range(0, 9) == 0) drain(1'b0);
         if ($urandom_range(0, 19) == 0)
            set_config($urandom, $urandom_range(0, 1 << 16), $urandom_range(0, 127));
      end
      calm = 0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      csr_wr_en  = 1'b0;
      csr_idx    = '0;
      csr_data   = '0;
      fail_count = 0; words_sent = 0; records_seen = 0; calm = 0;
      fermi_shadow = 0; tol_shadow = 66; kpts_shadow = 64;
      clear_stores();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      drain(1'b0);   // hold off until every record has come back
      test_config_sweep();
      test_random_sets();

      drain(1'b1);
      $display("covered %0d sample words and %0d result records", words_sent, records_seen);
      $display("over register sweeps, crossing, bracketless and in-tolerance sets");
      if (fail_count == 0 && pending_records.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

>>> filelist.f
+incdir+hdl
hdl/bgea_pkg.sv
hdl/bgea_ram.sv
hdl/band_gap_extrema_analyzer_core.sv
hdl/bgea_checker.sv
verif/tb.sv
